// ----- rtl/tbou_pkg.sv -----
// shared types, codes and constants of the two-bit occurrence bitmap unit
package tbou_pkg;

    localparam int unsigned RANGE_DEF   = 128;
    localparam int unsigned VPW_DEF     = 16;
    localparam int unsigned MAX_RESULTS = 16;
    localparam int unsigned CNT_W       = $clog2(MAX_RESULTS + 1);

    localparam int unsigned VALUE_W = 8;
    localparam int unsigned WORD_W  = 3;
    // scan values run up to eight words of at most 32 values
    localparam int unsigned SPAN_W  = 9;
    // no record or scan can reach an entry at or above this
    localparam int unsigned STORE_MAX = 256;

    // power of two, pointers wrap on their own
    localparam int unsigned QUEUE_DEPTH = 4;
    localparam int unsigned QPTR_W      = $clog2(QUEUE_DEPTH);

    localparam logic [1:0] CMD_RECORD = 2'd0;
    localparam logic [1:0] CMD_DUPS   = 2'd1;
    localparam logic [1:0] CMD_UNIQS  = 2'd2;

    localparam logic [1:0] SEEN_NEVER = 2'd0;
    localparam logic [1:0] SEEN_ONCE  = 2'd1;
    localparam logic [1:0] SEEN_MANY  = 2'd2;

    typedef enum logic [1:0] {
        OP_RECORD,
        OP_DUPS,
        OP_UNIQS
    } t_op;

    // arg is the store address for a record, the word index for a report
    typedef struct packed {
        t_op                  op;
        logic [VALUE_W-1:0]   arg;
    } t_qent;

    typedef enum logic [1:0] {
        ST_RUN,
        ST_SCAN,
        ST_FLUSH
    } t_state;

endpackage

// ----- rtl/tbou_front.sv -----
// front end: classifies incoming items and drops those with no effect
module tbou_front #(
    parameter int unsigned RANGE = tbou_pkg::RANGE_DEF
) (
    input  logic                            i_valid,
    input  logic                            i_q_full,
    input  logic [1:0]                      i_cmd,
    input  logic [tbou_pkg::VALUE_W-1:0]    i_value,
    input  logic [tbou_pkg::WORD_W-1:0]     i_word_index,
    output logic                            o_ready,
    output logic                            o_push,
    output tbou_pkg::t_qent                 o_ent
);

    localparam int unsigned VW    = tbou_pkg::VALUE_W;
    localparam int unsigned VW1   = tbou_pkg::VALUE_W + 1;
    localparam int unsigned LIMIT = (RANGE < tbou_pkg::STORE_MAX) ? RANGE : tbou_pkg::STORE_MAX;
    localparam logic [VW1-1:0] LIMIT_V = VW1'(LIMIT);

    logic in_range;
    logic keep;

    assign in_range = (i_value != '0) && ({1'b0, i_value} <= LIMIT_V);

    always_comb begin
        keep      = 1'b0;
        o_ent.op  = tbou_pkg::OP_RECORD;
        o_ent.arg = i_value - VW'(1);
        unique case (i_cmd)
            tbou_pkg::CMD_RECORD: begin
                keep = in_range;
            end
            tbou_pkg::CMD_DUPS: begin
                keep      = 1'b1;
                o_ent.op  = tbou_pkg::OP_DUPS;
                o_ent.arg = VW'(i_word_index);
            end
            tbou_pkg::CMD_UNIQS: begin
                keep      = 1'b1;
                o_ent.op  = tbou_pkg::OP_UNIQS;
                o_ent.arg = VW'(i_word_index);
            end
            default: begin
                keep = 1'b0;
            end
        endcase
    end

    assign o_ready = !i_q_full;
    assign o_push  = i_valid && !i_q_full && keep;

endmodule

// ----- rtl/tbou_queue.sv -----
// short command queue between the front end and the back end
module tbou_queue (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_push,
    input  tbou_pkg::t_qent i_ent,
    output logic            o_full,
    output logic            o_valid,
    output tbou_pkg::t_qent o_ent,
    input  logic            i_pop
);

    localparam int unsigned PW = tbou_pkg::QPTR_W;
    localparam int unsigned CW = tbou_pkg::QPTR_W + 1;
    localparam logic [CW-1:0] FULL_CNT = CW'(tbou_pkg::QUEUE_DEPTH);

    tbou_pkg::t_qent r_mem [tbou_pkg::QUEUE_DEPTH];
    logic [PW-1:0]   r_wr;
    logic [PW-1:0]   r_rd;
    logic [CW-1:0]   r_cnt;
    logic            do_push;
    logic            do_pop;

    assign o_full  = (r_cnt == FULL_CNT);
    assign o_valid = (r_cnt != '0);
    assign o_ent   = r_mem[r_rd];
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && o_valid;

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr] <= i_ent;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            if (do_push) begin
                r_wr <= r_wr + PW'(1);
            end
            if (do_pop) begin
                r_rd <= r_rd + PW'(1);
            end
            unique case ({do_push, do_pop})
                2'b10:   r_cnt <= r_cnt + CW'(1);
                2'b01:   r_cnt <= r_cnt - CW'(1);
                default: r_cnt <= r_cnt;
            endcase
        end
    end

endmodule

// ----- rtl/tbou_back.sv -----
// back end: occurrence store, record read-modify-write and word scan sequencer
module tbou_back #(
    parameter int unsigned RANGE           = tbou_pkg::RANGE_DEF,
    parameter int unsigned VALUES_PER_WORD = tbou_pkg::VPW_DEF
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_q_valid,
    input  tbou_pkg::t_qent                 i_q_ent,
    output logic                            o_q_pop,
    output logic                            o_valid,
    input  logic                            i_ready,
    output logic [tbou_pkg::VALUE_W-1:0]    o_found_value,
    output logic                            o_hit,
    output logic                            o_last
);

    localparam int unsigned DEPTH  = (RANGE < tbou_pkg::STORE_MAX) ? RANGE : tbou_pkg::STORE_MAX;
    localparam int unsigned ADDR_W = $clog2(DEPTH);
    localparam int unsigned POS_W  = $clog2(VALUES_PER_WORD + 1);
    localparam int unsigned SW     = tbou_pkg::SPAN_W;
    localparam int unsigned CW     = tbou_pkg::CNT_W;
    localparam int unsigned VW     = tbou_pkg::VALUE_W;
    localparam int unsigned WW     = tbou_pkg::WORD_W;

    localparam logic [SW-1:0]    VPW_S   = SW'(VALUES_PER_WORD);
    localparam logic [SW-1:0]    DEPTH_S = SW'(DEPTH);
    localparam logic [POS_W-1:0] VPW_P   = POS_W'(VALUES_PER_WORD);
    localparam logic [CW-1:0]    CAP_M1  = CW'(tbou_pkg::MAX_RESULTS - 1);
    localparam logic [CW-1:0]    CAP     = CW'(tbou_pkg::MAX_RESULTS);

    tbou_pkg::t_state r_state;
    tbou_pkg::t_state n_state;

    // occurrence store with a valid bit per entry in place of a clearing pass
    logic [1:0]       r_mem [DEPTH];
    logic [DEPTH-1:0] r_vld;
    logic [1:0]       r_q;
    logic             r_qv;

    logic              rd_en;
    logic [ADDR_W-1:0] rd_addr;
    logic              wr_en;
    logic [ADDR_W-1:0] wr_addr;
    logic [1:0]        wr_data;

    // record second stage and the write of the cycle before
    logic              r_rec_vld;
    logic [ADDR_W-1:0] r_rec_addr;
    logic              r_lw_vld;
    logic [ADDR_W-1:0] r_lw_addr;
    logic [1:0]        r_lw_val;

    // scan state
    logic [SW-1:0]     r_base;
    logic [POS_W-1:0]  r_pos;
    logic [1:0]        r_want;
    logic              r_rd_vld;
    logic [SW-1:0]     r_cur_val;
    logic              r_pend_vld;
    logic [SW-1:0]     r_pend_val;
    logic [CW-1:0]     r_nmatch;

    logic              r_out_vld;
    logic [VW-1:0]     r_out_val;
    logic              r_out_hit;
    logic              r_out_last;

    logic [1:0]        stored;
    logic              fwd;
    logic [1:0]        rec_old;
    logic [1:0]        rec_new;
    logic              out_free;
    logic [SW-1:0]     span;
    logic              more;
    logic              match;
    logic              need_emit;
    logic              stall;
    logic              cap_hit;
    logic              issue;
    logic              take;
    logic              take_rec;
    logic              take_rep;
    logic              emit;
    logic [VW-1:0]     e_val;
    logic              e_hit;
    logic              e_last;

    assign stored  = r_qv ? r_q : tbou_pkg::SEEN_NEVER;
    // the read of a back-to-back record on the same entry missed the last write
    assign fwd     = r_lw_vld && (r_lw_addr == r_rec_addr);
    assign rec_old = fwd ? r_lw_val : stored;
    assign rec_new = (rec_old == tbou_pkg::SEEN_NEVER) ? tbou_pkg::SEEN_ONCE
                                                       : tbou_pkg::SEEN_MANY;

    assign out_free  = !r_out_vld || i_ready;
    assign span      = r_base + SW'(r_pos);
    assign more      = (r_pos < VPW_P) && (span < DEPTH_S);
    assign match     = (r_state == tbou_pkg::ST_SCAN) && r_rd_vld && (stored == r_want);
    // a new match releases the one held back, which then cannot be the last
    assign need_emit = match && r_pend_vld;
    assign stall     = need_emit && !out_free;
    assign cap_hit   = match && (r_nmatch == CAP_M1);
    assign issue     = (r_state == tbou_pkg::ST_SCAN) && !stall && more && !cap_hit;

    assign take     = (r_state == tbou_pkg::ST_RUN) && i_q_valid;
    assign take_rec = take && (i_q_ent.op == tbou_pkg::OP_RECORD);
    assign take_rep = take && (i_q_ent.op != tbou_pkg::OP_RECORD);
    assign o_q_pop  = take;

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            tbou_pkg::ST_RUN: begin
                if (take_rep) begin
                    n_state = tbou_pkg::ST_SCAN;
                end
            end
            tbou_pkg::ST_SCAN: begin
                if (!stall && !issue) begin
                    n_state = tbou_pkg::ST_FLUSH;
                end
            end
            tbou_pkg::ST_FLUSH: begin
                if (out_free) begin
                    n_state = tbou_pkg::ST_RUN;
                end
            end
            default: begin
                n_state = tbou_pkg::ST_RUN;
            end
        endcase
    end

    always_comb begin
        rd_en   = take_rec || issue;
        rd_addr = take_rec ? i_q_ent.arg[ADDR_W-1:0] : span[ADDR_W-1:0];
        wr_en   = r_rec_vld;
        wr_addr = r_rec_addr;
        wr_data = rec_new;
        emit    = 1'b0;
        e_val   = '0;
        e_hit   = 1'b0;
        e_last  = 1'b0;
        unique case (r_state)
            tbou_pkg::ST_SCAN: begin
                if (need_emit && out_free) begin
                    emit  = 1'b1;
                    e_val = r_pend_val[VW-1:0];
                    e_hit = 1'b1;
                end
            end
            tbou_pkg::ST_FLUSH: begin
                if (out_free) begin
                    emit   = 1'b1;
                    e_val  = r_pend_vld ? r_pend_val[VW-1:0] : '0;
                    e_hit  = r_pend_vld;
                    e_last = 1'b1;
                end
            end
            default: begin
                emit = 1'b0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= tbou_pkg::ST_RUN;
        end else begin
            r_state <= n_state;
        end
    end

    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            r_mem[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            r_q  <= r_mem[rd_addr];
            r_qv <= r_vld[rd_addr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (wr_en) begin
            r_vld[wr_addr] <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rec_vld <= 1'b0;
            r_lw_vld  <= 1'b0;
        end else begin
            r_rec_vld <= take_rec;
            r_lw_vld  <= wr_en;
        end
    end

    always_ff @(posedge i_clk) begin
        if (take_rec) begin
            r_rec_addr <= rd_addr;
        end
        r_lw_addr <= r_rec_addr;
        r_lw_val  <= rec_new;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos      <= '0;
            r_rd_vld   <= 1'b0;
            r_pend_vld <= 1'b0;
            r_nmatch   <= '0;
        end else if (take_rep) begin
            r_pos      <= '0;
            r_rd_vld   <= 1'b0;
            r_pend_vld <= 1'b0;
            r_nmatch   <= '0;
        end else if ((r_state == tbou_pkg::ST_SCAN) && !stall) begin
            r_rd_vld <= issue;
            if (issue) begin
                r_pos <= r_pos + POS_W'(1);
            end
            if (match) begin
                r_pend_vld <= 1'b1;
                r_nmatch   <= r_nmatch + CW'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (take_rep) begin
            r_base <= SW'(i_q_ent.arg[WW-1:0]) * VPW_S;
            r_want <= (i_q_ent.op == tbou_pkg::OP_DUPS) ? tbou_pkg::SEEN_MANY
                                                        : tbou_pkg::SEEN_ONCE;
        end
        if (issue) begin
            r_cur_val <= span + SW'(1);
        end
        if (match && !stall) begin
            r_pend_val <= r_cur_val;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld <= 1'b0;
        end else if (emit) begin
            r_out_vld <= 1'b1;
        end else if (i_ready) begin
            r_out_vld <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (emit) begin
            r_out_val  <= e_val;
            r_out_hit  <= e_hit;
            r_out_last <= e_last;
        end
    end

    assign o_valid       = r_out_vld;
    assign o_found_value = r_out_val;
    assign o_hit         = r_out_hit;
    assign o_last        = r_out_last;

    a_emit_room: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        emit |-> out_free)
        else $error("result written over an item not yet taken");

    a_rec_in_run: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state != tbou_pkg::ST_RUN) |-> !r_rec_vld)
        else $error("record write overlaps a word scan");

    a_match_cap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_nmatch <= CAP)
        else $error("match count beyond the result cap");

    a_flush_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == tbou_pkg::ST_FLUSH && out_free)
        |=> (r_state == tbou_pkg::ST_RUN && r_out_vld && r_out_last))
        else $error("report did not close with a last item");

endmodule

// ----- rtl/two_bit_occurrence_bitmap_unit.sv -----
// top level of the two-bit occurrence bitmap unit
//
//   channel   valid     ready     payload
//   in        i_valid   o_ready   i_cmd, i_value, i_word_index
//   out       o_valid   i_ready   o_found_value, o_hit, o_last
//
// records run one per cycle outside reports: a store read then write, with the
// previous write forwarded when the same entry is hit in consecutive cycles
// a report loads its word, reads the store once per value in it up to the
// result cap or store end, then closes with a last item; output stalls hold it
// reset clears the per-entry valid bits at once, so no clearing pass is needed
// o_ready drops only while the four-entry command queue is full
module two_bit_occurrence_bitmap_unit #(
    parameter int unsigned RANGE           = tbou_pkg::RANGE_DEF,
    parameter int unsigned VALUES_PER_WORD = tbou_pkg::VPW_DEF
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_valid,
    output logic                            o_ready,
    input  logic [1:0]                      i_cmd,
    input  logic [tbou_pkg::VALUE_W-1:0]    i_value,
    input  logic [tbou_pkg::WORD_W-1:0]     i_word_index,
    output logic                            o_valid,
    input  logic                            i_ready,
    output logic [tbou_pkg::VALUE_W-1:0]    o_found_value,
    output logic                            o_hit,
    output logic                            o_last
);

    logic            q_full;
    logic            q_push;
    tbou_pkg::t_qent q_in;
    logic            q_valid;
    tbou_pkg::t_qent q_out;
    logic            q_pop;

    tbou_front #(
        .RANGE (RANGE)
    ) u_front (
        .i_valid      (i_valid),
        .i_q_full     (q_full),
        .i_cmd        (i_cmd),
        .i_value      (i_value),
        .i_word_index (i_word_index),
        .o_ready      (o_ready),
        .o_push       (q_push),
        .o_ent        (q_in)
    );

    tbou_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (q_push),
        .i_ent   (q_in),
        .o_full  (q_full),
        .o_valid (q_valid),
        .o_ent   (q_out),
        .i_pop   (q_pop)
    );

    tbou_back #(
        .RANGE           (RANGE),
        .VALUES_PER_WORD (VALUES_PER_WORD)
    ) u_back (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_q_valid     (q_valid),
        .i_q_ent       (q_out),
        .o_q_pop       (q_pop),
        .o_valid       (o_valid),
        .i_ready       (i_ready),
        .o_found_value (o_found_value),
        .o_hit         (o_hit),
        .o_last        (o_last)
    );

endmodule

// ----- bench/testbench.sv -----
// self-checking bench for the two-bit occurrence bitmap unit
`timescale 1ns / 1ps

module testbench;

    localparam logic [1:0] CMD_SPARE  = 2'd3;
    localparam int         RANGE_N    = tbou_pkg::RANGE_DEF;
    localparam int         VPW        = tbou_pkg::VPW_DEF;
    localparam int         VW         = tbou_pkg::VALUE_W;
    localparam int         WW         = tbou_pkg::WORD_W;
    localparam int         HOLD_LEN   = 200;
    localparam int         DIR_N      = 23;

    typedef struct packed {
        logic [VW-1:0] value;
        logic          hit;
        logic          last;
    } t_find;

    // cmd, value, word, typed, typed result
    typedef struct packed {
        logic [1:0]    cmd;
        logic [VW-1:0] value;
        logic [WW-1:0] word;
        logic          typed;
        t_find         res;
    } t_row;

    localparam t_find NO_HIT = {8'd0, 1'b0, 1'b1};

    logic                 i_clk        = 1'b0;
    logic                 i_rst_n      = 1'b0;
    logic                 i_valid      = 1'b0;
    logic [1:0]           i_cmd        = 2'd0;
    logic [VW-1:0]        i_value      = '0;
    logic [WW-1:0]        i_word_index = '0;
    logic                 i_ready      = 1'b0;
    logic                 o_ready;
    logic                 o_valid;
    logic [VW-1:0]        o_found_value;
    logic                 o_hit;
    logic                 o_last;

    two_bit_occurrence_bitmap_unit u_top (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_valid       (i_valid),
        .o_ready       (o_ready),
        .i_cmd         (i_cmd),
        .i_value       (i_value),
        .i_word_index  (i_word_index),
        .o_valid       (o_valid),
        .i_ready       (i_ready),
        .o_found_value (o_found_value),
        .o_hit         (o_hit),
        .o_last        (o_last)
    );

    always #5 i_clk = ~i_clk;

    // bench copy of the occurrence table, indexed by value
    logic [1:0] seen_tbl [1:RANGE_N];
    t_find      scan_buf [0:tbou_pkg::MAX_RESULTS-1];
    t_find      finds_due [$];
    t_row       dir_tbl [0:DIR_N-1];

    int  send_idle_pct = 0;
    int  recv_idle_pct = 0;
    bit  hold_req      = 1'b0;
    int  items_in      = 0;
    int  live_items    = 0;
    int  reports_in    = 0;
    int  results_seen  = 0;
    int  mismatches    = 0;

    // advances the table for a record, fills scan_buf for a report
    function automatic int bitmap_step(logic [1:0] c, logic [VW-1:0] v,
                                       logic [WW-1:0] w);
        int         n;
        int         val;
        logic [1:0] want;
        n = 0;
        if (c == tbou_pkg::CMD_RECORD) begin
            if (v >= 1 && v <= RANGE_N)
                seen_tbl[v] = (seen_tbl[v] == tbou_pkg::SEEN_NEVER) ? tbou_pkg::SEEN_ONCE
                                                                     : tbou_pkg::SEEN_MANY;
            return 0;
        end
        if (c == CMD_SPARE)
            return 0;
        want = (c == tbou_pkg::CMD_DUPS) ? tbou_pkg::SEEN_MANY : tbou_pkg::SEEN_ONCE;
        for (int l = 0; l < VPW && n < tbou_pkg::MAX_RESULTS; l++) begin
            val = int'(w) * VPW + l + 1;
            if (val > RANGE_N)
                break;
            if (seen_tbl[val] == want) begin
                scan_buf[n] = {val[VW-1:0], 1'b1, 1'b0};
                n++;
            end
        end
        if (n == 0) begin
            scan_buf[0] = NO_HIT;
            n = 1;
        end else begin
            scan_buf[n-1].last = 1'b1;
        end
        return n;
    endfunction

    task automatic send_item(input logic [1:0] c, input logic [VW-1:0] v,
                             input logic [WW-1:0] w, input logic typed,
                             input t_find typed_res);
        int n;
        while ($urandom_range(0, 99) < send_idle_pct) begin
            i_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_valid      <= 1'b1;
        i_cmd        <= c;
        i_value      <= v;
        i_word_index <= w;
        do @(posedge i_clk); while (!o_ready);
        items_in++;
        n = bitmap_step(c, v, w);
        if (!(c == CMD_SPARE || (c == tbou_pkg::CMD_RECORD && (v == 0 || v > RANGE_N))))
            live_items++;
        if (c == tbou_pkg::CMD_DUPS || c == tbou_pkg::CMD_UNIQS)
            reports_in++;
        if (typed) begin
            finds_due.push_back(typed_res);
        end else begin
            for (int i = 0; i < n; i++)
                finds_due.push_back(scan_buf[i]);
        end
    endtask

    task automatic wait_drained();
        i_valid <= 1'b0;
        while (finds_due.size() != 0)
            @(posedge i_clk);
    endtask

    task automatic random_phase(input int quota);
        int         target;
        int         pick;
        int         w;
        int         k;
        logic [1:0] rc;
        target = live_items + quota;
        while (live_items < target) begin
            pick = $urandom_range(0, 99);
            rc   = $urandom_range(0, 1) ? tbou_pkg::CMD_DUPS : tbou_pkg::CMD_UNIQS;
            w    = $urandom_range(0, 7);
            if (pick < 55) begin
                // burst of records into one word, then a report on it
                k = $urandom_range(1, 12);
                repeat (k)
                    send_item(tbou_pkg::CMD_RECORD, VW'(w * VPW + $urandom_range(1, VPW)),
                              WW'($urandom_range(0, 7)), 1'b0, NO_HIT);
                send_item(rc, VW'($urandom_range(0, 255)), WW'(w), 1'b0, NO_HIT);
            end else if (pick < 62) begin
                // every value of a word, so the report can fill all slots
                for (int l = 1; l <= VPW; l++)
                    send_item(tbou_pkg::CMD_RECORD, VW'(w * VPW + l),
                              WW'($urandom_range(0, 7)), 1'b0, NO_HIT);
                send_item(rc, VW'($urandom_range(0, 255)), WW'(w), 1'b0, NO_HIT);
            end else if (pick < 82) begin
                send_item(rc, VW'($urandom_range(0, 255)), WW'(w), 1'b0, NO_HIT);
            end else begin
                send_item(2'($urandom_range(0, 3)), VW'($urandom_range(0, 255)), WW'(w),
                          1'b0, NO_HIT);
            end
        end
    endtask

    // receiver side, with a long hold-off on request
    initial begin
        forever begin
            @(posedge i_clk);
            if (hold_req) begin
                i_ready <= 1'b0;
                repeat (HOLD_LEN) @(posedge i_clk);
                hold_req = 1'b0;
            end else begin
                i_ready <= ($urandom_range(0, 99) >= recv_idle_pct);
            end
        end
    end

    always @(posedge i_clk) begin : result_check
        t_find want;
        if (i_rst_n && o_valid && i_ready) begin
            results_seen++;
            if (finds_due.size() == 0) begin
                $error("unexpected item: found_value %0d hit %0d last %0d",
                       o_found_value, o_hit, o_last);
                mismatches++;
            end else begin
                want = finds_due.pop_front();
                if (o_found_value !== want.value) begin
                    $error("found_value: expected %0d, got %0d", want.value, o_found_value);
                    mismatches++;
                end
                if (o_hit !== want.hit) begin
                    $error("hit: expected %0d, got %0d", want.hit, o_hit);
                    mismatches++;
                end
                if (o_last !== want.last) begin
                    $error("last: expected %0d, got %0d", want.last, o_last);
                    mismatches++;
                end
            end
        end
    end

    initial begin
        #5_000_000;
        $display("[FAIL] regression broken");
        $finish;
    end

    initial begin
        for (int v = 1; v <= RANGE_N; v++)
            seen_tbl[v] = tbou_pkg::SEEN_NEVER;
        // empty table, ignored records and the spare code come first
        dir_tbl[0]  = {tbou_pkg::CMD_DUPS,   8'd0,   3'd0, 1'b1, NO_HIT};
        dir_tbl[1]  = {tbou_pkg::CMD_UNIQS,  8'd0,   3'd7, 1'b1, NO_HIT};
        dir_tbl[2]  = {tbou_pkg::CMD_UNIQS,  8'd255, 3'd0, 1'b1, NO_HIT};
        dir_tbl[3]  = {tbou_pkg::CMD_RECORD, 8'd0,   3'd0, 1'b0, NO_HIT};
        dir_tbl[4]  = {tbou_pkg::CMD_RECORD, 8'd255, 3'd7, 1'b0, NO_HIT};
        dir_tbl[5]  = {tbou_pkg::CMD_RECORD, 8'd129, 3'd0, 1'b0, NO_HIT};
        dir_tbl[6]  = {CMD_SPARE,            8'd85,  3'd5, 1'b0, NO_HIT};
        dir_tbl[7]  = {tbou_pkg::CMD_UNIQS,  8'd0,   3'd0, 1'b1, NO_HIT};
        dir_tbl[8]  = {tbou_pkg::CMD_RECORD, 8'd1,   3'd0, 1'b0, NO_HIT};
        dir_tbl[9]  = {tbou_pkg::CMD_RECORD, 8'd128, 3'd7, 1'b0, NO_HIT};
        dir_tbl[10] = {tbou_pkg::CMD_RECORD, 8'd16,  3'd0, 1'b0, NO_HIT};
        dir_tbl[11] = {tbou_pkg::CMD_RECORD, 8'd17,  3'd2, 1'b0, NO_HIT};
        dir_tbl[12] = {tbou_pkg::CMD_UNIQS,  8'd0,   3'd0, 1'b0, NO_HIT};
        dir_tbl[13] = {tbou_pkg::CMD_RECORD, 8'd1,   3'd0, 1'b0, NO_HIT};
        // many stays many
        dir_tbl[14] = {tbou_pkg::CMD_RECORD, 8'd1,   3'd0, 1'b0, NO_HIT};
        dir_tbl[15] = {tbou_pkg::CMD_DUPS,   8'd0,   3'd0, 1'b0, NO_HIT};
        dir_tbl[16] = {tbou_pkg::CMD_UNIQS,  8'd0,   3'd0, 1'b0, NO_HIT};
        dir_tbl[17] = {tbou_pkg::CMD_UNIQS,  8'd0,   3'd7, 1'b0, NO_HIT};
        dir_tbl[18] = {tbou_pkg::CMD_RECORD, 8'd128, 3'd7, 1'b0, NO_HIT};
        dir_tbl[19] = {tbou_pkg::CMD_DUPS,   8'd0,   3'd7, 1'b0, NO_HIT};
        dir_tbl[20] = {tbou_pkg::CMD_UNIQS,  8'd0,   3'd7, 1'b1, NO_HIT};
        dir_tbl[21] = {tbou_pkg::CMD_UNIQS,  8'd0,   3'd1, 1'b0, NO_HIT};
        dir_tbl[22] = {tbou_pkg::CMD_DUPS,   8'd0,   3'd3, 1'b1, NO_HIT};

        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;

        for (int r = 0; r < DIR_N; r++)
            send_item(dir_tbl[r].cmd, dir_tbl[r].value, dir_tbl[r].word,
                      dir_tbl[r].typed, dir_tbl[r].res);
        wait_drained();

        send_idle_pct = 11;
        recv_idle_pct = 78;
        random_phase(80);
        wait_drained();

        send_idle_pct = 78;
        recv_idle_pct = 11;
        random_phase(80);
        wait_drained();

        // no idling, but the receiver stalls long enough to back up the input
        send_idle_pct = 0;
        recv_idle_pct = 0;
        hold_req      = 1'b1;
        random_phase(80);
        wait_drained();

        repeat (4 * VPW) @(posedge i_clk);

        $display("covered %0d items (%0d reports), %0d results checked, %0d mismatches",
                 items_in, reports_in, results_seen, mismatches);
        if (mismatches == 0 && finds_due.size() == 0) begin
            $display("[ OK ] regression clean");
        end else begin
            $display("[FAIL] regression broken");
        end
        $finish;
    end

endmodule
